/* rtl/nbpt_pkg.sv */
// ----------------------------------------------------------------------------
// nbpt_pkg
// Types and constants of the naive Bayes pixel trainer: the transaction
// structs of both channels, action codes and the fixed arithmetic limits.
// ----------------------------------------------------------------------------
`default_nettype none

package nbpt_pkg;

  // action codes of an input transaction
  localparam logic [1:0] ACT_TRAIN = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_CLASS = 2'd2;

  // characters that mark a shaded pixel
  localparam logic [7:0] CHAR_HASH = 8'h23;
  localparam logic [7:0] CHAR_PLUS = 8'h2B;

  // counter ceiling and Q1.16 one
  localparam logic [15:0] CNT_MAX = 16'hFFFF;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  // fraction bits produced by the divider, one per cycle
  localparam int unsigned QBITS  = 16;
  localparam int unsigned DIV_CW = $clog2(QBITS);

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] row;
    logic [5:0] col;
    logic [7:0] pixel_char;
    logic       shade_asked;
    logic [3:0] label;
    logic       image_end;
  } in_t;

  typedef struct packed {
    logic [16:0] probability;
    logic        divide_error;
  } out_t;

  // saturating increment of a 16 bit counter
  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

`default_nettype wire

/* rtl/naive_bayes_pixel_trainer.sv */
// ----------------------------------------------------------------------------
// naive_bayes_pixel_trainer
// Bernoulli naive Bayes trainer over shaded pixels with Laplace smoothing.
// Shaded counts live in one synchronous memory updated read-modify-write;
// queries run through a shared restoring divider, one quotient bit a cycle.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------
//  in      | input     | in_valid_i / in_stall_o   | in_data_i  (nbpt_pkg::in_t)
//  out     | output    | out_valid_o / out_stall_i | out_data_o (nbpt_pkg::out_t)
//  cfg     | input     | cfg_we_i                  | cfg_wdata_i (smoothing k)
//
//  Training transactions are taken one per cycle while in_stall_o is low; the
//  memory read happens at accept and the write back in the next cycle, with
//  forwarding for repeats. A query is accepted and its count read from memory;
//  the divider then runs (skipped for a zero divisor or a ratio of one or
//  more); input stalls until the divider hands its result to the output
//  register. After reset a clearing pass over all WIDTH*WIDTH*CLASSES cells
//  (7840 at the defaults) zeroes the count memory; input stalls meanwhile.
//  The output register holds under out_stall_i; training continues behind it.
`default_nettype none

module naive_bayes_pixel_trainer #(
  parameter int unsigned WIDTH   = 28,
  parameter int unsigned CLASSES = 10
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire nbpt_pkg::in_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output nbpt_pkg::out_t     out_data_o,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i
);
  import nbpt_pkg::*;

  localparam int unsigned DEPTH = WIDTH * WIDTH * CLASSES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = (CLASSES > 2) ? $clog2(CLASSES) : 1;

  // divider states
  localparam logic [1:0] DIV_IDLE = 2'd0;
  localparam logic [1:0] DIV_RUN  = 2'd1;
  localparam logic [1:0] DIV_DONE = 2'd2;

  // shaded count memory
  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  // registers
  logic [7:0]        k_q;
  logic [15:0]       class_cnt_q [CLASSES];
  logic [15:0]       total_q;
  logic              clr_active_q;
  logic [AW-1:0]     clr_cnt_q;
  logic              s1_valid_q;
  logic [1:0]        s1_act_q;
  logic [AW-1:0]     s1_addr_q;
  logic              s1_cnt_ok_q;
  logic              s1_lab_ok_q;
  logic              s1_shade_q;
  logic [CW-1:0]     s1_label_q;
  logic              last_wr_valid_q;
  logic [AW-1:0]     last_wr_addr_q;
  logic [15:0]       last_wr_data_q;
  logic [1:0]        div_state_q, div_state_d;
  logic [DIV_CW-1:0] div_cnt_q;
  logic [16:0]       rem_q, den_q;
  logic [15:0]       quot_q;
  out_t              res_q;
  logic              out_valid_q;
  out_t              out_data_q;

  // accept side decode
  logic          in_acc;
  logic          pos_ok, lab_ok, shaded;
  logic [31:0]   addr_full;
  logic [AW-1:0] addr;
  logic [CW-1:0] lab_idx;

  assign in_stall_o = clr_active_q || (div_state_q != DIV_IDLE) ||
                      (s1_valid_q && (s1_act_q != ACT_TRAIN));
  assign in_acc  = in_valid_i && !in_stall_o;
  assign pos_ok  = ({1'b0, in_data_i.row} < 7'(WIDTH)) &&
                   ({1'b0, in_data_i.col} < 7'(WIDTH));
  assign lab_ok  = {1'b0, in_data_i.label} < 5'(CLASSES);
  assign shaded  = (in_data_i.pixel_char == CHAR_HASH) ||
                   (in_data_i.pixel_char == CHAR_PLUS);
  assign addr_full = (32'(in_data_i.row) * 32'(WIDTH) + 32'(in_data_i.col)) *
                     32'(CLASSES) + 32'(in_data_i.label);
  assign addr    = addr_full[AW-1:0];
  assign lab_idx = in_data_i.label[CW-1:0];

  // stage one: write back or operand setup
  logic          s1_wr;
  logic [15:0]   cnt_raw, cnt, freq, n_cnt, wdata;
  logic [16:0]   num, den;
  logic          fwd_hit, q_start;

  assign s1_wr   = s1_valid_q && (s1_act_q == ACT_TRAIN);
  assign q_start = s1_valid_q && (s1_act_q != ACT_TRAIN);
  assign fwd_hit = last_wr_valid_q && (last_wr_addr_q == s1_addr_q);
  assign cnt_raw = fwd_hit ? last_wr_data_q : rdata_q;
  assign wdata   = sat_inc(cnt_raw);

  always_comb begin
    cnt   = s1_cnt_ok_q ? cnt_raw : 16'd0;
    freq  = s1_lab_ok_q ? class_cnt_q[s1_label_q] : 16'd0;
    n_cnt = s1_shade_q ? cnt : ((freq > cnt) ? freq - cnt : 16'd0);
    if (s1_act_q == ACT_PIXEL) begin
      num = 17'(k_q) + 17'(n_cnt);
      den = {8'd0, k_q, 1'b0} + 17'(freq);
    end else begin
      num = 17'(k_q) + 17'(freq);
      den = 17'(k_q) * 17'(CLASSES) + 17'(total_q);
    end
  end

  // memory write port: clearing pass or training write back
  always_ff @(posedge clk_i) begin
    if (clr_active_q) begin
      mem[clr_cnt_q] <= 16'd0;
    end else if (s1_wr) begin
      mem[s1_addr_q] <= wdata;
    end
  end

  // memory read port, registered data
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      rdata_q <= mem[addr];
    end
  end

  // configuration, clearing pass and class counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q          <= 8'd1;
      total_q      <= 16'd0;
      clr_active_q <= 1'b1;
      clr_cnt_q    <= '0;
      for (int i = 0; i < CLASSES; i++) class_cnt_q[i] <= 16'd0;
    end else begin
      if (cfg_we_i) begin
        k_q <= cfg_wdata_i;
      end
      if (clr_active_q) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(DEPTH - 1)) begin
          clr_active_q <= 1'b0;
        end
      end
      if (in_acc && (in_data_i.action == ACT_TRAIN) && lab_ok && in_data_i.image_end) begin
        class_cnt_q[lab_idx] <= sat_inc(class_cnt_q[lab_idx]);
        total_q              <= sat_inc(total_q);
      end
    end
  end

  // stage one control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q      <= 1'b0;
      last_wr_valid_q <= 1'b0;
    end else begin
      unique case (in_data_i.action)
        ACT_TRAIN: s1_valid_q <= in_acc && lab_ok && pos_ok && shaded;
        ACT_PIXEL,
        ACT_CLASS: s1_valid_q <= in_acc;
        default:   s1_valid_q <= 1'b0;
      endcase
      last_wr_valid_q <= s1_wr;
    end
  end

  // stage one payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_act_q    <= in_data_i.action;
      s1_addr_q   <= addr;
      s1_cnt_ok_q <= pos_ok && lab_ok;
      s1_lab_ok_q <= lab_ok;
      s1_shade_q  <= in_data_i.shade_asked;
      s1_label_q  <= lab_idx;
    end
    if (s1_wr) begin
      last_wr_addr_q <= s1_addr_q;
      last_wr_data_q <= wdata;
    end
  end

  // divider step
  logic [17:0] rem_sh;
  logic        ge;
  logic [16:0] rem_nx;
  logic [15:0] quot_nx;
  logic        out_load;

  assign rem_sh  = {rem_q, 1'b0};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_nx  = ge ? 17'(rem_sh - {1'b0, den_q}) : rem_sh[16:0];
  assign quot_nx = {quot_q[14:0], ge};
  assign out_load = (div_state_q == DIV_DONE) && (!out_valid_q || !out_stall_i);

  // divider sequencer
  always_comb begin
    div_state_d = div_state_q;
    unique case (div_state_q)
      DIV_IDLE: begin
        if (q_start) begin
          div_state_d = ((den == 17'd0) || (num >= den)) ? DIV_DONE : DIV_RUN;
        end
      end
      DIV_RUN: begin
        if (div_cnt_q == DIV_CW'(QBITS - 1)) div_state_d = DIV_DONE;
      end
      DIV_DONE: begin
        if (out_load) div_state_d = DIV_IDLE;
      end
      default: div_state_d = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_state_q <= DIV_IDLE;
      div_cnt_q   <= '0;
    end else begin
      div_state_q <= div_state_d;
      if (div_state_q == DIV_RUN) begin
        div_cnt_q <= div_cnt_q + DIV_CW'(1);
      end else begin
        div_cnt_q <= '0;
      end
    end
  end

  // divider datapath and result
  always_ff @(posedge clk_i) begin
    if ((div_state_q == DIV_IDLE) && q_start) begin
      rem_q  <= num;
      den_q  <= den;
      quot_q <= 16'd0;
      if (den == 17'd0) begin
        res_q.probability  <= 17'd0;
        res_q.divide_error <= 1'b1;
      end else begin
        res_q.probability  <= ONE_Q16;
        res_q.divide_error <= 1'b0;
      end
    end else if (div_state_q == DIV_RUN) begin
      rem_q  <= rem_nx;
      quot_q <= quot_nx;
      if (div_cnt_q == DIV_CW'(QBITS - 1)) begin
        res_q.probability  <= {1'b0, quot_nx};
        res_q.divide_error <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

/* rtl/nbpt_checker.sv */
// ----------------------------------------------------------------------------
// nbpt_checker
// Port-level checks of the naive Bayes pixel trainer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nbpt_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_stall_o,
  input wire logic           out_valid_o,
  input wire logic           out_stall_i,
  input wire nbpt_pkg::out_t out_data_o
);
  import nbpt_pkg::*;

  // a stalled result transaction keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("result payload changed while stalled");

  // a zero divisor always reports probability zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.divide_error) |-> (out_data_o.probability == 17'd0))
    else $error("divide error with nonzero probability");

  // probabilities never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.probability <= ONE_Q16))
    else $error("probability above one");

  // the input is held off while in reset and at the start of the clearing pass
  assert property (@(posedge clk_i)
    !rst_ni |=> in_stall_o)
    else $error("input accepted during count clearing");

endmodule

bind naive_bayes_pixel_trainer nbpt_checker u_nbpt_checker (.*);

`default_nettype wire

/* test/tb_naive_bayes_pixel_trainer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_naive_bayes_pixel_trainer
// Self-checking bench for the naive Bayes pixel trainer. A queue of pixel and
// query transactions feeds a clocked driver. A local count model predicts the
// smoothed Q1.16 answer of every query. A clocked monitor compares each
// answer with the oldest prediction. Phases cover several smoothing
// constants, random idling on both channels, a long output hold-off and
// back to back training of one pixel.
// ----------------------------------------------------------------------------

module tb_naive_bayes_pixel_trainer;
  import nbpt_pkg::*;

  localparam int unsigned WIDTH         = 28;
  localparam int unsigned CLASSES       = 10;
  localparam int unsigned CELLS         = WIDTH * WIDTH * CLASSES;
  // one query: accept, memory read, 16 divider steps, output register
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 300;
  // longest quiet stretch is the clearing pass over all 7840 count cells after reset
  localparam int unsigned QUIET_LIMIT   = 40000;
  localparam int unsigned SHOWN_ERRORS  = 10;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  in_t        in_data     = '0;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  out_t       out_data;
  logic       cfg_we      = 1'b0;
  logic [7:0] cfg_wdata   = 8'd0;

  // pending input transactions and predicted answers
  in_t  pixel_feed[$];
  out_t awaited_probs[$];

  // count model
  bit [15:0]   shaded_tally [CELLS] = '{default: '0};
  bit [15:0]   class_tally [CLASSES] = '{default: '0};
  bit [15:0]   image_tally = '0;
  logic [7:0]  model_k = 8'd1;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  logic        pressure_on = 1'b0;
  int unsigned mismatch_count = 0;

  naive_bayes_pixel_trainer #(
    .WIDTH   (WIDTH),
    .CLASSES (CLASSES)
  ) uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // truncated Q1.16 ratio, capped at one, zero divisor flagged
  function automatic out_t laplace_q16(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    out_t        r;
    if (den == 64'd0) begin
      r.probability  = '0;
      r.divide_error = 1'b1;
    end else begin
      q = (num << 16) / den;
      if (q > ONE_Q16) q = ONE_Q16;
      r.probability  = q[16:0];
      r.divide_error = 1'b0;
    end
    return r;
  endfunction

  // apply one accepted transaction to the counts, predict the query answer
  task automatic update_counts_and_predict(input in_t item);
    logic        pos_ok;
    logic        lab_ok;
    int unsigned slot;
    logic [63:0] k;
    logic [63:0] freq;
    logic [63:0] cnt;
    logic [63:0] n;
    pos_ok = (item.row < WIDTH) && (item.col < WIDTH);
    lab_ok = item.label < CLASSES;
    k      = model_k;
    freq   = lab_ok ? class_tally[item.label] : 64'd0;
    slot   = (pos_ok && lab_ok) ? (item.row * WIDTH + item.col) * CLASSES + item.label : 0;
    case (item.action)
      ACT_TRAIN: begin
        if (lab_ok) begin
          if (pos_ok && (item.pixel_char == CHAR_HASH || item.pixel_char == CHAR_PLUS) &&
              shaded_tally[slot] != CNT_MAX)
            shaded_tally[slot] += 16'd1;
          if (item.image_end) begin
            if (class_tally[item.label] != CNT_MAX) class_tally[item.label] += 16'd1;
            if (image_tally != CNT_MAX) image_tally += 16'd1;
          end
        end
      end
      ACT_PIXEL: begin
        cnt = (pos_ok && lab_ok) ? shaded_tally[slot] : 64'd0;
        if (item.shade_asked) n = cnt;
        else n = (freq > cnt) ? freq - cnt : 64'd0;
        awaited_probs = {awaited_probs, laplace_q16(k + n, 2 * k + freq)};
      end
      ACT_CLASS: begin
        awaited_probs = {awaited_probs, laplace_q16(k + freq, CLASSES * k + image_tally)};
      end
      default: ;
    endcase
  endtask

  // driver: hold a stalled transaction, otherwise offer the next one or idle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) update_counts_and_predict(pixel_feed.pop_front());
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (pixel_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= pixel_feed[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long output hold-off, counted in its own process
  int unsigned hold_cnt = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni && pressure_on && !hold_done) begin
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
    end
  end

  // monitor: check answers and drive output stall
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (awaited_probs.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOWN_ERRORS)
            $display("unexpected answer: prob %0d err %0d",
                     out_data.probability, out_data.divide_error);
        end else begin
          want = awaited_probs.pop_front();
          if (out_data.probability !== want.probability ||
              out_data.divide_error !== want.divide_error) begin
            mismatch_count++;
            if (mismatch_count <= SHOWN_ERRORS)
              $display("mismatch: expected prob %0d err %0d, got prob %0d err %0d",
                       want.probability, want.divide_error,
                       out_data.probability, out_data.divide_error);
          end
        end
      end
      out_stall <= (pressure_on && !hold_done) || ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] action, input logic [5:0] row,
                            input logic [5:0] col, input logic [7:0] ch,
                            input logic shade, input logic [3:0] label,
                            input logic iend);
    in_t item;
    item.action      = action;
    item.row         = row;
    item.col         = col;
    item.pixel_char  = ch;
    item.shade_asked = shade;
    item.label       = label;
    item.image_end   = iend;
    pixel_feed = {pixel_feed, item};
  endtask

  // positions mostly in a small hot corner so counts build up
  function automatic logic [5:0] pick_coord();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return 6'($urandom_range(3));
    if (r < 95) return 6'($urandom_range(WIDTH - 1));
    return 6'($urandom_range(63));
  endfunction

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return CHAR_HASH;
    if (r < 50) return CHAR_PLUS;
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [3:0] pick_label();
    if ($urandom_range(99) < 10) return 4'($urandom_range(15));
    return 4'($urandom_range(CLASSES - 1));
  endfunction

  // short labelled images mixed with queries and some raw noise
  task automatic queue_random_traffic(input int unsigned count);
    int unsigned made;
    int unsigned r;
    int unsigned len;
    logic [3:0]  lab;
    logic [31:0] rnd;
    logic [$bits(in_t)-1:0] raw;
    made = 0;
    while (made < count) begin
      r = $urandom_range(99);
      if (r < 50) begin
        lab = ($urandom_range(99) < 5) ? 4'($urandom_range(15, CLASSES))
                                       : 4'($urandom_range(CLASSES - 1));
        len = $urandom_range(6, 1);
        for (int i = 0; i < len; i++)
          queue_item(ACT_TRAIN, pick_coord(), pick_coord(), pick_char(),
                     1'($urandom_range(1)), lab, i == len - 1);
        made += len;
      end else if (r < 85) begin
        queue_item(ACT_PIXEL, pick_coord(), pick_coord(), 8'($urandom_range(255)),
                   1'($urandom_range(1)), pick_label(), 1'($urandom_range(1)));
        made++;
      end else if (r < 95) begin
        queue_item(ACT_CLASS, 6'($urandom_range(63)), 6'($urandom_range(63)),
                   8'($urandom_range(255)), 1'($urandom_range(1)),
                   4'($urandom_range(15)), 1'($urandom_range(1)));
        made++;
      end else begin
        rnd = $urandom;
        raw = rnd[$bits(in_t)-1:0];
        pixel_feed = {pixel_feed, in_t'(raw)};
        made++;
      end
    end
  endtask

  // wait for every transaction and answer, then let the divider go quiet
  task automatic drain_and_settle();
    while (pixel_feed.size() != 0 || awaited_probs.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_smoothing(input logic [7:0] value);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    model_k = value;
    @(negedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty model with k of zero, then corner cases
    write_smoothing(8'd0);
    queue_item(ACT_CLASS, 6'd0, 6'd0, 8'h00, 1'b0, 4'd0, 1'b0);   // zero divisor
    queue_item(ACT_PIXEL, 6'd0, 6'd0, 8'h00, 1'b1, 4'd0, 1'b0);   // zero divisor
    queue_item(ACT_PIXEL, 6'd63, 6'd63, 8'hFF, 1'b0, 4'd15, 1'b1);
    queue_item(2'b11, 6'd63, 6'd63, 8'hFF, 1'b1, 4'd15, 1'b1);     // unknown action
    queue_item(ACT_TRAIN, 6'd0, 6'd0, CHAR_HASH, 1'b0, 4'd12, 1'b1); // bad label
    queue_item(ACT_TRAIN, 6'd0, 6'd0, CHAR_HASH, 1'b0, 4'd3, 1'b0);
    queue_item(ACT_TRAIN, 6'd0, 6'd0, CHAR_PLUS, 1'b1, 4'd3, 1'b0);
    queue_item(ACT_PIXEL, 6'd0, 6'd0, 8'h00, 1'b1, 4'd3, 1'b0);
    queue_item(ACT_TRAIN, 6'd27, 6'd27, 8'h2E, 1'b0, 4'd3, 1'b1);
    queue_item(ACT_PIXEL, 6'd0, 6'd0, 8'h00, 1'b1, 4'd3, 1'b0);   // ratio above one
    queue_item(ACT_PIXEL, 6'd0, 6'd0, 8'h00, 1'b0, 4'd3, 1'b0);   // unshaded underflow
    queue_item(ACT_TRAIN, 6'd40, 6'd5, CHAR_HASH, 1'b0, 4'd3, 1'b1); // off image, counted
    queue_item(ACT_PIXEL, 6'd40, 6'd5, 8'h00, 1'b0, 4'd3, 1'b0);
    queue_item(ACT_CLASS, 6'd0, 6'd0, 8'h00, 1'b0, 4'd3, 1'b0);
    queue_item(ACT_CLASS, 6'd0, 6'd0, 8'h00, 1'b0, 4'd9, 1'b0);
    queue_item(ACT_CLASS, 6'd0, 6'd0, 8'h00, 1'b0, 4'd15, 1'b0);
    queue_item(ACT_TRAIN, 6'd27, 6'd0, 8'hFF, 1'b1, 4'd9, 1'b1);
    queue_item(ACT_TRAIN, 6'd0, 6'd27, 8'h00, 1'b0, 4'd0, 1'b1);
    queue_item(ACT_TRAIN, 6'd5, 6'd5, CHAR_HASH, 1'b0, 4'd9, 1'b1);
    queue_item(ACT_PIXEL, 6'd5, 6'd5, 8'h00, 1'b1, 4'd9, 1'b0);
    queue_item(ACT_PIXEL, 6'd5, 6'd5, 8'h00, 1'b0, 4'd9, 1'b0);
    queue_item(ACT_CLASS, 6'd0, 6'd0, 8'h00, 1'b0, 4'd9, 1'b0);
    drain_and_settle();

    // random with sender idling less than receiver, largest k
    write_smoothing(8'd255);
    send_idle_pct = 33;
    recv_idle_pct = 51;
    queue_random_traffic(130);
    drain_and_settle();

    // random with the idle ratios swapped and a long output hold-off
    write_smoothing(8'($urandom_range(254, 2)));
    send_idle_pct = 51;
    recv_idle_pct = 33;
    pressure_on   = 1'b1;
    queue_random_traffic(130);
    drain_and_settle();

    // no idling, then hammer one pixel back to back
    write_smoothing(8'd1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_traffic(130);
    for (int i = 0; i < 8; i++)
      queue_item(ACT_TRAIN, 6'd1, 6'd1, CHAR_HASH, 1'b0, 4'd2, 1'b1);
    queue_item(ACT_PIXEL, 6'd1, 6'd1, 8'h00, 1'b1, 4'd2, 1'b0);
    queue_item(ACT_PIXEL, 6'd1, 6'd1, 8'h00, 1'b0, 4'd2, 1'b0);
    queue_item(ACT_CLASS, 6'd0, 6'd0, 8'h00, 1'b0, 4'd2, 1'b0);
    queue_item(ACT_CLASS, 6'd0, 6'd0, 8'h00, 1'b0, 4'd5, 1'b0);
    queue_random_traffic(20);
    drain_and_settle();

    if (mismatch_count == 0 && awaited_probs.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
